/* design/bdsl_pkg.sv */
// ----------------------------------------------------------------------------
// bdsl_pkg
// Shared types and constants for the button debounce / short-long press unit.
// ----------------------------------------------------------------------------
package bdsl_pkg;

  // Fixed field widths
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned DEB_W      = 10;
  localparam int unsigned LONG_W     = 16;
  localparam int unsigned LEVELS_W   = 4;
  localparam int unsigned NUM_OUT    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TICK_MS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 2'd2;

  // Register reset values
  localparam logic [TICK_W-1:0] TICK_MS_RST       = 10'd10;
  localparam logic [DEB_W-1:0]  DEBOUNCE_MS_RST   = 10'd20;
  localparam logic [LONG_W-1:0] LONG_PRESS_MS_RST = 16'd2000;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_LONG     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef struct packed {
    logic [TICK_W-1:0] tick_ms;
    logic [DEB_W-1:0]  debounce_ms;
    logic [LONG_W-1:0] long_press_ms;
  } cfg_t;

endpackage

/* design/bdsl_lane.sv */
// ----------------------------------------------------------------------------
// bdsl_lane
// One button: phase machine with saturating debounce and hold counters.
// ----------------------------------------------------------------------------
module bdsl_lane (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             down_i,
  input  bdsl_pkg::cfg_t   cfg_i,
  output bdsl_pkg::event_e ev_o
);
  import bdsl_pkg::*;

  phase_e            phase_q, phase_d;
  logic [DEB_W-1:0]  deb_q, deb_d;
  logic [LONG_W-1:0] held_q, held_d;

  logic [DEB_W:0]    deb_sum;
  logic [LONG_W:0]   held_sum;
  logic              deb_hit;
  logic              held_hit;
  logic              held_below;

  assign deb_sum    = {1'b0, deb_q} + {{(DEB_W+1-TICK_W){1'b0}}, cfg_i.tick_ms};
  assign held_sum   = {1'b0, held_q} + {{(LONG_W+1-TICK_W){1'b0}}, cfg_i.tick_ms};
  assign deb_hit    = deb_sum >= {1'b0, cfg_i.debounce_ms};
  assign held_hit   = held_sum >= {1'b0, cfg_i.long_press_ms};
  assign held_below = held_q < cfg_i.long_press_ms;

  // Next state
  always_comb begin
    phase_d = phase_q;
    deb_d   = deb_q;
    held_d  = held_q;
    case (phase_q)
      PH_IDLE: begin
        if (down_i) begin
          phase_d = PH_DEBOUNCE;
          deb_d   = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (down_i) begin
          if (deb_hit) begin
            phase_d = PH_PRESSED;
            deb_d   = cfg_i.debounce_ms;
            held_d  = '0;
          end else begin
            deb_d = deb_sum[DEB_W-1:0];
          end
        end else begin
          phase_d = PH_IDLE;
          deb_d   = '0;
        end
      end
      PH_PRESSED: begin
        if (down_i) begin
          if (held_hit) begin
            phase_d = PH_LONG;
            held_d  = cfg_i.long_press_ms;
          end else begin
            held_d = held_sum[LONG_W-1:0];
          end
        end else begin
          phase_d = PH_IDLE;
          deb_d   = '0;
          held_d  = '0;
        end
      end
      PH_LONG: begin
        if (!down_i) begin
          phase_d = PH_IDLE;
          deb_d   = '0;
          held_d  = '0;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Event output
  always_comb begin
    ev_o = EV_NONE;
    case (phase_q)
      PH_PRESSED: begin
        if (down_i) begin
          if (held_hit) ev_o = EV_LONG;
        end else if (held_below) begin
          ev_o = EV_SHORT;
        end
      end
      PH_LONG: begin
        if (!down_i) ev_o = EV_LONG;
      end
      default: begin
        ev_o = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      deb_q   <= '0;
      held_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      deb_q   <= deb_d;
      held_q  <= held_d;
    end
  end

`ifndef ASSERT_OFF
  a_release_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !down_i |=> phase_q == PH_IDLE)
    else $error("lane not idle after a released tick");

  a_idle_to_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && down_i && phase_q == PH_IDLE |=> phase_q == PH_DEBOUNCE)
    else $error("press from idle skipped debounce");

  a_short_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_o == EV_SHORT |-> phase_q == PH_PRESSED && !down_i)
    else $error("short event outside a release from pressed");
`endif

endmodule

/* design/button_debounce_short_long_press_unit.sv */
// ----------------------------------------------------------------------------
// button_debounce_short_long_press_unit
// Debounces four buttons and reports short and long presses per scan tick.
// ----------------------------------------------------------------------------
// Each input item is one scan tick carrying the pressed level of every button.
// Every item yields exactly one result item with one event code per button
// (0 none, 1 short, 2 long). A button must be seen pressed for debounce_ms of
// accumulated tick time (at least one tick in debounce) before it counts; a
// confirmed press that reaches long_press_ms reports long at once, a release
// before that reports short, and a release after the long event reports long
// again. Both counters saturate at their thresholds. The block takes one item
// per clock cycle while results are taken: the item lands in an input
// register, all button machines update in a single pass of adder/compare
// logic, and the events land in the result register that drives out_valid_o.
// The result register is the only buffer on the output side; while it holds
// an untaken result the input register still accepts one more item. Write the
// configuration registers (0 tick_ms, 1 debounce_ms, 2 long_press_ms) only
// while no item is in flight; writes to other indexes are dropped.
// ----------------------------------------------------------------------------
module button_debounce_short_long_press_unit #(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  pressed_levels_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_button0_o,
  output logic [1:0]  event_button1_o,
  output logic [1:0]  event_button2_o,
  output logic [1:0]  event_button3_o
);
  import bdsl_pkg::*;

  // Buttons beyond the width of the level field never see a press and never
  // reach an output, so they carry no state.
  localparam int unsigned NUM_LANES = (NUM_BUTTONS < NUM_OUT) ? NUM_BUTTONS : NUM_OUT;

  cfg_t                cfg_q;
  logic                s1_valid_q;
  logic [LEVELS_W-1:0] s1_levels_q;
  logic                s1_adv;
  logic                out_valid_q;
  event_e              ev_q [NUM_OUT];
  event_e              ev_d [NUM_OUT];
  event_e              lane_ev [NUM_LANES];

  // Advance the input register into the result register when that is free
  // or being taken this cycle.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_ms       <= TICK_MS_RST;
      cfg_q.debounce_ms   <= DEBOUNCE_MS_RST;
      cfg_q.long_press_ms <= LONG_PRESS_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TICK_MS:       cfg_q.tick_ms       <= cfg_wdata_i[TICK_W-1:0];
        REG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_wdata_i[DEB_W-1:0];
        REG_LONG_PRESS_MS: cfg_q.long_press_ms <= cfg_wdata_i[LONG_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Input register: hold the item until the lanes take it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_levels_q <= pressed_levels_i;
    end
  end

  // One machine per button; all step together on an advance.
  for (genvar b = 0; b < NUM_LANES; b++) begin : g_lane
    bdsl_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (s1_adv),
      .down_i (s1_levels_q[b]),
      .cfg_i  (cfg_q),
      .ev_o   (lane_ev[b])
    );
  end

  for (genvar i = 0; i < NUM_OUT; i++) begin : g_out
    if (i < NUM_LANES) begin : g_used
      assign ev_d[i] = lane_ev[i];
    end else begin : g_absent
      assign ev_d[i] = EV_NONE;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ev_q <= ev_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_button0_o = ev_q[0];
  assign event_button1_o = ev_q[1];
  assign event_button2_o = ev_q[2];
  assign event_button3_o = ev_q[3];

`ifndef ASSERT_OFF
  a_accept_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted item missing from input register");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced item missing from result register");

  a_stalled_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_levels_q))
    else $error("stalled item lost from input register");
`endif

endmodule
